### design/pnch_pkg.sv
// Shared constants and functions for the column height noise pipeline.
`timescale 1ns / 1ps
package pnch_pkg;

   localparam logic [2:0] CSR_FREQUENCY   = 3'd0;
   localparam logic [2:0] CSR_AMPLITUDE   = 3'd1;
   localparam logic [2:0] CSR_QUANT_LVLS  = 3'd2;
   localparam logic [2:0] CSR_BASE_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_MIN_HEIGHT  = 3'd4;
   localparam logic [2:0] CSR_MAX_HEIGHT  = 3'd5;

   localparam logic [31:0] HASH_M1 = 32'd3284157443;
   localparam logic [31:0] HASH_M2 = 32'd1911520717;
   localparam logic [31:0] HASH_M3 = 32'd2048419325;

   localparam longint PI_HALF_Q30 = 64'sd1686629713;
   localparam longint ONE_Q30     = 64'sd1073741824;

   localparam int NOISE_W = 19;
   localparam int DIV_W   = 20;
   localparam int DN_W    = 12;

   function automatic logic [31:0] rot16(input logic [31:0] v);
      return {v[15:0], v[31:16]};
   endfunction

   function automatic longint quarter_sine(input longint q, input int ab);
      longint x;
      longint x2;
      longint t;
      x  = (q * PI_HALF_Q30) >>> (ab - 2);
      x2 = (x * x) >>> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >>> 30) / 110;
      t  = ONE_Q30 - ((x2 * t) >>> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >>> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >>> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >>> 30) / 6;
      return (((x * t) >>> 30) + 64'sd32768) >>> 16;
   endfunction

endpackage

### design/pnch_hash.sv
// Three-stage multiply-rotate lattice corner hash.
`timescale 1ns / 1ps
module pnch_hash #(
   parameter int ANGLE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [31:0]           ci,
   input  logic [31:0]           cj,
   output logic [ANGLE_BITS-1:0] k
);
   import pnch_pkg::*;

   logic [31:0] a_ff, j_ff, b_ff, a2_ff, c_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff  <= 32'(ci * HASH_M1);
         j_ff  <= cj;
         b_ff  <= 32'((j_ff ^ rot16(a_ff)) * HASH_M2);
         a2_ff <= a_ff;
         c_ff  <= 32'((a2_ff ^ rot16(b_ff)) * HASH_M3);
      end
   end

   assign k = c_ff[31 -: ANGLE_BITS];

endmodule

### design/pnch_grad.sv
// Gradient lookup from a quarter-wave sine ROM and corner dot product.
`timescale 1ns / 1ps
module pnch_grad #(
   parameter int ANGLE_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [ANGLE_BITS-1:0]               k,
   input  logic signed [FRAC_BITS:0]           dx,
   input  logic signed [FRAC_BITS:0]           dy,
   output logic signed [pnch_pkg::NOISE_W-1:0] dot
);
   import pnch_pkg::*;

   localparam int QN = 1 << (ANGLE_BITS - 2);
   localparam int PW = FRAC_BITS + 17;
   localparam int SW = FRAC_BITS + 18;

   logic [14:0] rom [QN+1];
   logic signed [15:0] g_in [2];
   logic signed [15:0] g_ff [2];
   logic signed [FRAC_BITS:0] dx_ff, dy_ff;
   logic signed [PW-1:0] px_ff, py_ff;
   logic signed [SW-1:0] sum;
   logic signed [NOISE_W-1:0] dot_ff;

   for (genvar r = 0; r <= QN; r++) begin : g_rom
      assign rom[r] = 15'(quarter_sine(longint'(r), ANGLE_BITS));
   end

   for (genvar g = 0; g < 2; g++) begin : g_look
      logic [ANGLE_BITS-1:0] p;
      logic [ANGLE_BITS-2:0] idx;
      always_comb begin
         p = k + ANGLE_BITS'(g * QN);
         if (p[ANGLE_BITS-2]) begin
            idx = (ANGLE_BITS-1)'(QN) - {1'b0, p[ANGLE_BITS-3:0]};
         end else begin
            idx = {1'b0, p[ANGLE_BITS-3:0]};
         end
         if (p[ANGLE_BITS-1]) begin
            g_in[g] = -$signed({1'b0, rom[idx]});
         end else begin
            g_in[g] = $signed({1'b0, rom[idx]});
         end
      end
   end

   assign sum = SW'(px_ff) + SW'(py_ff) + SW'(64'sd1 <<< (FRAC_BITS - 3));

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff[0] <= g_in[0];
         g_ff[1] <= g_in[1];
         dx_ff   <= dx;
         dy_ff   <= dy;
         px_ff   <= PW'(dx_ff) * PW'(g_ff[0]);
         py_ff   <= PW'(dy_ff) * PW'(g_ff[1]);
         dot_ff  <= sum[FRAC_BITS-2 +: NOISE_W];
      end
   end

   assign dot = dot_ff;

endmodule

### design/pnch_fade.sv
// Four-stage quintic fade curve, Q0.16 in, Q1.16 out.
`timescale 1ns / 1ps
module pnch_fade (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] t,
   output logic [16:0] u
);
   import pnch_pkg::*;

   logic signed [21:0] a_c;
   logic signed [38:0] p_ff, q_ff;
   logic [31:0] tt_ff, t3p_ff;
   logic [15:0] t1_ff;
   logic signed [21:0] b_ff;
   logic [16:0] u_ff;

   assign a_c = 22'sd6 * $signed({6'b0, t}) - 22'sd983040;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= 39'($signed({1'b0, t})) * 39'(a_c);
         tt_ff  <= 32'(t * t);
         t1_ff  <= t;
         b_ff   <= 22'(p_ff >>> 16) + 22'sd655360;
         t3p_ff <= 32'(tt_ff[31:16] * t1_ff);
         q_ff   <= 39'($signed({1'b0, t3p_ff[31:16]})) * 39'(b_ff);
         u_ff   <= q_ff[32:16];
      end
   end

   assign u = u_ff;

endmodule

### design/pnch_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module pnch_div #(
   parameter int DW = 20,
   parameter int SW = 13
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] dvd,
   input  logic [7:0]    dvs,
   input  logic [SW-1:0] side_in,
   output logic [DW-1:0] quo,
   output logic [SW-1:0] side_out
);
   import pnch_pkg::*;

   logic [7:0]    rem_ff  [DW];
   logic [DW-1:0] x_ff    [DW];
   logic [SW-1:0] s_ff    [DW];

   for (genvar g = 0; g < DW; g++) begin : g_stage
      logic [7:0]    rem_p;
      logic [DW-1:0] x_p;
      logic [SW-1:0] s_p;
      logic [8:0]    cat;
      logic          ge;
      logic [8:0]    diff;
      if (g == 0) begin : g_first
         assign rem_p = 8'd0;
         assign x_p   = dvd;
         assign s_p   = side_in;
      end else begin : g_next
         assign rem_p = rem_ff[g-1];
         assign x_p   = x_ff[g-1];
         assign s_p   = s_ff[g-1];
      end
      assign cat  = {rem_p, x_p[DW-1]};
      assign ge   = cat >= {1'b0, dvs};
      assign diff = cat - {1'b0, dvs};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= ge ? diff[7:0] : cat[7:0];
            x_ff[g]   <= {x_p[DW-2:0], ge};
            s_ff[g]   <= s_p;
         end
      end
   end

   assign quo      = x_ff[DW-1];
   assign side_out = s_ff[DW-1];

endmodule

### design/perlin_noise_column_height.sv
// Column height generator: 2D gradient noise, quantize, scale, offset and clamp.
//
// req_ carries one column per transaction (world_x, world_z); rsp_ returns one
// column height per transaction, in order. The csr_ port writes the six
// registers (frequency, amplitude, quantize_levels, base_height, min_height,
// max_height) by index; write only while no column is in flight.
// The datapath has 36 register stages: 15 for noise and scaling, 20 for the
// quotient pipeline of the quantizing division and one for offset and clamp.
// Throughput is one column per cycle while the response side is not stalled.
// The whole pipeline advances together: when rsp_tvalid is high and
// rsp_tready low, every stage holds and req_tready drops, so no transaction
// is lost or repeated. Bubbles travel as cleared valid bits.
// Synchronous reset clears all valid bits and loads the register defaults
// (frequency 2048, amplitude 8192, quantize_levels 0, base 64, min 0,
// max 255). req_tready stays low during reset; the block accepts
// transactions in the cycle after reset.
`timescale 1ns / 1ps
module perlin_noise_column_height #(
   parameter int ANGLE_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // world_x[23:0], world_z[47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // column_height[15:0]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import pnch_pkg::*;

   localparam int UP  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int DN  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int LAT = 16 + DIV_W;
   localparam int SBW = DN_W + 1;

   logic [15:0] freq_ff, amp_ff;
   logic [7:0]  lvls_ff;
   logic signed [15:0] base_ff, min_ff, max_ff;
   logic [LAT:1] v_ff;
   logic en;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= 16'd2048;
         amp_ff  <= 16'd8192;
         lvls_ff <= 8'd0;
         base_ff <= 16'sd64;
         min_ff  <= 16'sd0;
         max_ff  <= 16'sd255;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FREQUENCY:   freq_ff <= csr_wdata;
            CSR_AMPLITUDE:   amp_ff  <= csr_wdata;
            CSR_QUANT_LVLS:  lvls_ff <= csr_wdata[7:0];
            CSR_BASE_HEIGHT: base_ff <= csr_wdata;
            CSR_MIN_HEIGHT:  min_ff  <= csr_wdata;
            CSR_MAX_HEIGHT:  max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en         = !v_ff[LAT] || rsp_tready;
   assign req_tready = en && !reset;
   assign rsp_tvalid = v_ff[LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-1:1], req_tvalid};
      end
   end

   // stage 1: scale coordinates into lattice cell and fraction
   logic signed [40:0] px_in, pz_in;
   logic signed [63:0] sx_in, sz_in;
   logic signed [23:0] cellx_ff, cellz_ff;
   logic [FRAC_BITS-1:0] fx_ff, fz_ff;
   logic [15:0] tx_ff, tz_ff;

   assign px_in = 41'($signed(req_tdata[23:0])) * 41'($signed({1'b0, freq_ff}));
   assign pz_in = 41'($signed(req_tdata[47:24])) * 41'($signed({1'b0, freq_ff}));
   assign sx_in = (64'(px_in) <<< UP) >>> DN;
   assign sz_in = (64'(pz_in) <<< UP) >>> DN;

   always_ff @(posedge clock) begin
      if (en) begin
         cellx_ff <= px_in[39:16];
         cellz_ff <= pz_in[39:16];
         fx_ff    <= sx_in[FRAC_BITS-1:0];
         fz_ff    <= sz_in[FRAC_BITS-1:0];
         tx_ff    <= (px_in[15:0] >> DN) << DN;
         tz_ff    <= (pz_in[15:0] >> DN) << DN;
      end
   end

   // stages 2-4: corner hashes
   logic [31:0] ix0, ix1, iz0, iz1;
   logic [ANGLE_BITS-1:0] k00, k10, k01, k11;

   assign ix0 = 32'(cellx_ff);
   assign iz0 = 32'(cellz_ff);
   assign ix1 = ix0 + 32'd1;
   assign iz1 = iz0 + 32'd1;

   pnch_hash #(.ANGLE_BITS(ANGLE_BITS)) u_hash00 (
      .clock(clock), .en(en), .ci(ix0), .cj(iz0), .k(k00));
   pnch_hash #(.ANGLE_BITS(ANGLE_BITS)) u_hash10 (
      .clock(clock), .en(en), .ci(ix1), .cj(iz0), .k(k10));
   pnch_hash #(.ANGLE_BITS(ANGLE_BITS)) u_hash01 (
      .clock(clock), .en(en), .ci(ix0), .cj(iz1), .k(k01));
   pnch_hash #(.ANGLE_BITS(ANGLE_BITS)) u_hash11 (
      .clock(clock), .en(en), .ci(ix1), .cj(iz1), .k(k11));

   logic [FRAC_BITS-1:0] fxd_ff [2:4];
   logic [FRAC_BITS-1:0] fzd_ff [2:4];

   always_ff @(posedge clock) begin
      if (en) begin
         fxd_ff[2] <= fx_ff;
         fxd_ff[3] <= fxd_ff[2];
         fxd_ff[4] <= fxd_ff[3];
         fzd_ff[2] <= fz_ff;
         fzd_ff[3] <= fzd_ff[2];
         fzd_ff[4] <= fzd_ff[3];
      end
   end

   // stages 5-7: gradients and dot products
   logic signed [FRAC_BITS:0] dx0, dx1, dz0, dz1;
   logic signed [NOISE_W-1:0] n00, n10, n01, n11;

   assign dx0 = $signed({1'b0, fxd_ff[4]});
   assign dx1 = $signed({1'b1, fxd_ff[4]});
   assign dz0 = $signed({1'b0, fzd_ff[4]});
   assign dz1 = $signed({1'b1, fzd_ff[4]});

   pnch_grad #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_grad00 (
      .clock(clock), .en(en), .k(k00), .dx(dx0), .dy(dz0), .dot(n00));
   pnch_grad #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_grad10 (
      .clock(clock), .en(en), .k(k10), .dx(dx1), .dy(dz0), .dot(n10));
   pnch_grad #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_grad01 (
      .clock(clock), .en(en), .k(k01), .dx(dx0), .dy(dz1), .dot(n01));
   pnch_grad #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_grad11 (
      .clock(clock), .en(en), .k(k11), .dx(dx1), .dy(dz1), .dot(n11));

   // stages 2-5: fade weights, then align to the lerps
   logic [16:0] u_w, v_w;
   logic [16:0] ud_ff [6:7];
   logic [16:0] vd_ff [6:9];

   pnch_fade u_fade_x (.clock(clock), .en(en), .t(tx_ff), .u(u_w));
   pnch_fade u_fade_z (.clock(clock), .en(en), .t(tz_ff), .u(v_w));

   always_ff @(posedge clock) begin
      if (en) begin
         ud_ff[6] <= u_w;
         ud_ff[7] <= ud_ff[6];
         vd_ff[6] <= v_w;
         vd_ff[7] <= vd_ff[6];
         vd_ff[8] <= vd_ff[7];
         vd_ff[9] <= vd_ff[8];
      end
   end

   // stages 8-11: bilinear blend
   logic signed [19:0] d0, d1, d2;
   logic signed [37:0] lp0_ff, lp1_ff, lq_ff;
   logic signed [NOISE_W-1:0] a0_ff, a1_ff, l0_ff, l1_ff, b0_ff, n_ff;

   assign d0 = 20'(n10) - 20'(n00);
   assign d1 = 20'(n11) - 20'(n01);
   assign d2 = 20'(l1_ff) - 20'(l0_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         lp0_ff <= 38'($signed({1'b0, ud_ff[7]})) * 38'(d0);
         lp1_ff <= 38'($signed({1'b0, ud_ff[7]})) * 38'(d1);
         a0_ff  <= n00;
         a1_ff  <= n01;
         l0_ff  <= a0_ff + NOISE_W'(lp0_ff >>> 16);
         l1_ff  <= a1_ff + NOISE_W'(lp1_ff >>> 16);
         lq_ff  <= 38'($signed({1'b0, vd_ff[9]})) * 38'(d2);
         b0_ff  <= l0_ff;
         n_ff   <= b0_ff + NOISE_W'(lq_ff >>> 16);
      end
   end

   // stages 12-15: quantize and scale
   logic signed [27:0] nl_ff;
   logic signed [35:0] na_ff;
   logic [27:0] nl_mag;
   logic [35:0] na_mag;
   logic [11:0] r_mag, dn_mag;
   logic signed [11:0] r_ff;
   logic signed [DN_W-1:0] dn_ff, dn2_ff, dn3_ff;
   logic signed [28:0] ra_ff;
   logic [28:0] ra_mag;
   logic [28:0] m_sum;
   logic [DIV_W-1:0] dvd_ff;
   logic neg_ff;

   assign nl_mag = nl_ff[27] ? 28'(-nl_ff) : 28'(nl_ff);
   assign na_mag = na_ff[35] ? 36'(-na_ff) : 36'(na_ff);
   assign r_mag  = 12'((nl_mag + 28'd32768) >> 16);
   assign dn_mag = 12'((na_mag + 36'd8388608) >> 24);
   assign ra_mag = ra_ff[28] ? 29'(-ra_ff) : 29'(ra_ff);
   assign m_sum  = ra_mag + {14'b0, lvls_ff, 7'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         nl_ff  <= 28'(n_ff) * 28'($signed({1'b0, lvls_ff}));
         na_ff  <= 36'(n_ff) * 36'($signed({1'b0, amp_ff}));
         r_ff   <= nl_ff[27] ? -$signed(r_mag) : $signed(r_mag);
         dn_ff  <= na_ff[35] ? -$signed(dn_mag) : $signed(dn_mag);
         ra_ff  <= 29'(r_ff) * 29'($signed({1'b0, amp_ff}));
         dn2_ff <= dn_ff;
         dvd_ff <= m_sum[8 +: DIV_W];
         neg_ff <= ra_ff[28];
         dn3_ff <= dn2_ff;
      end
   end

   // stages 16-35: divide by the level count
   logic [DIV_W-1:0] quo;
   logic [SBW-1:0] side_out;

   pnch_div #(.DW(DIV_W), .SW(SBW)) u_div (
      .clock(clock), .en(en), .dvd(dvd_ff), .dvs(lvls_ff),
      .side_in({neg_ff, dn3_ff}), .quo(quo), .side_out(side_out));

   // stage 36: offset and clamp
   logic signed [21:0] delta, h, hmin, hmax;
   logic signed [15:0] height_ff;

   always_comb begin
      if (lvls_ff > 8'd1) begin
         delta = side_out[SBW-1] ? -22'($signed({1'b0, quo})) : 22'($signed({1'b0, quo}));
      end else begin
         delta = 22'($signed(side_out[DN_W-1:0]));
      end
      hmin = 22'(min_ff);
      hmax = 22'(max_ff);
      h    = 22'(base_ff) + delta;
      if (h < hmin) begin
         h = hmin;
      end
      if (h > hmax) begin
         h = hmax;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         height_ff <= h[15:0];
      end
   end

   assign rsp_tdata = height_ff;

endmodule
